[rtl/core/b58d_pkg.sv]
package b58d_pkg;

	// default output length in bytes
	localparam int OUT_BYTES_DEF = 25;

	// radix of the text digits
	localparam int RADIX = 58;

	// depth of the command queue between front and back
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

	// one classified item as it travels from front to back
	typedef struct packed {
		logic       is_char;   // a character is present
		logic       bad_char;  // character outside the alphabet
		logic       is_end;    // last item of the string
		logic [5:0] digit;     // digit value 0..57
	} b58d_op_t;

	typedef struct packed {
		logic       valid;
		logic [5:0] digit;
	} b58d_digit_t;

	// alphabet 1-9 A-H J-N P-Z a-k m-z
	function automatic b58d_digit_t char_to_digit(input logic [7:0] ch);
		b58d_digit_t r;
		r.valid = 1'b1;
		r.digit = 6'd0;
		if (ch >= 8'h31 && ch <= 8'h39) begin
			r.digit = 6'(ch - 8'h31);
		end else if (ch >= 8'h41 && ch <= 8'h48) begin
			r.digit = 6'(ch - 8'h41 + 8'd9);
		end else if (ch >= 8'h4a && ch <= 8'h4e) begin
			r.digit = 6'(ch - 8'h4a + 8'd17);
		end else if (ch >= 8'h50 && ch <= 8'h5a) begin
			r.digit = 6'(ch - 8'h50 + 8'd22);
		end else if (ch >= 8'h61 && ch <= 8'h6b) begin
			r.digit = 6'(ch - 8'h61 + 8'd33);
		end else if (ch >= 8'h6d && ch <= 8'h7a) begin
			r.digit = 6'(ch - 8'h6d + 8'd44);
		end else begin
			r.valid = 1'b0;
		end
		return r;
	endfunction

endpackage

[rtl/core/base58_decoder_unit.sv]
// Base58 text decoder. Each input transfer carries one ASCII character of a
// Base58 string (char_present) and/or the end mark (end_of_string). A front
// stage maps the character to its digit and drops items that carry neither;
// a two-entry queue hands the rest to a back end that multiplies a
// little-endian array of (OUT_BYTES+3)/4 32-bit words by 58 and adds the
// digit, one word per cycle through a single 32x6 multiplier. A character
// therefore occupies the back end for its pop and one multiply-add step
// per word, and the queue lets the front keep taking up to two items
// meanwhile. On the end mark the block sends OUT_BYTES result
// transfers, most significant byte first, one per cycle while out_ready is
// high, with last_byte on the final one and decode_ok high. A character
// outside the alphabet, a carry out of the top word or any bit set above
// OUT_BYTES*8 makes the whole string fail: later characters are skipped and
// the end mark yields a single transfer with out_byte 0, decode_ok 0 and
// last_byte 1. An end mark with no characters gives OUT_BYTES zero bytes.
// State clears after each string; no checksum or leading-zero check is done.
module base58_decoder_unit #(
	parameter int OUT_BYTES = b58d_pkg::OUT_BYTES_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	// input channel
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] text_char,
	input  logic       char_present,
	input  logic       end_of_string,
	// result channel
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic       decode_ok,
	output logic       last_byte
);

	// classified items between front and queue
	logic               push;
	b58d_pkg::b58d_op_t push_op;
	logic               q_full;

	// queue to back end
	logic               pop;
	b58d_pkg::b58d_op_t pop_op;
	logic               q_empty;

	// front: digit lookup and filtering of empty items
	b58d_front u_front (
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.text_char     (text_char),
		.char_present  (char_present),
		.end_of_string (end_of_string),
		.q_full        (q_full),
		.push          (push),
		.push_op       (push_op)
	);

	// decouples the front from the multi-cycle back end
	b58d_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_op (push_op),
		.full    (q_full),
		.pop     (pop),
		.pop_op  (pop_op),
		.empty   (q_empty)
	);

	// back: word-serial multiply-add and byte-serial result output
	b58d_back #(
		.OUT_BYTES (OUT_BYTES)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.pop_op    (pop_op),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_byte  (out_byte),
		.decode_ok (decode_ok),
		.last_byte (last_byte)
	);

	// a failed decode is always a single, zero-valued, final transfer
	a_err_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !decode_ok |-> last_byte && out_byte == 8'h00)
		else $error("error result is not a single zero final transfer");

	// the back end only pops when the queue holds an item
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_empty)
		else $error("pop from empty queue");

	// the front never pushes into a full queue
	a_push_notfull: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_full)
		else $error("push into full queue");

endmodule

[rtl/core/b58d_front.sv]
module b58d_front (
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [7:0]         text_char,
	input  logic               char_present,
	input  logic               end_of_string,
	input  logic               q_full,
	output logic               push,
	output b58d_pkg::b58d_op_t push_op
);

	b58d_pkg::b58d_digit_t dig;

	assign dig = b58d_pkg::char_to_digit(text_char);

	assign in_ready = !q_full;

	// items with neither a character nor an end mark do nothing and are dropped
	assign push = in_valid && !q_full && (char_present || end_of_string);

	always_comb begin
		push_op.is_char  = char_present;
		push_op.bad_char = char_present && !dig.valid;
		push_op.is_end   = end_of_string;
		push_op.digit    = dig.digit;
	end

endmodule

[rtl/core/b58d_queue.sv]
module b58d_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  b58d_pkg::b58d_op_t push_op,
	output logic               full,
	input  logic               pop,
	output b58d_pkg::b58d_op_t pop_op,
	output logic               empty
);

	localparam int PW = b58d_pkg::QPTR_W;
	localparam int CW = $clog2(b58d_pkg::QUEUE_DEPTH + 1);

	b58d_pkg::b58d_op_t entry_q [b58d_pkg::QUEUE_DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full   = (count_q == CW'(b58d_pkg::QUEUE_DEPTH));
	assign empty  = (count_q == '0);
	assign pop_op = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_op;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(b58d_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(b58d_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

[rtl/core/b58d_back.sv]
module b58d_back #(
	parameter int OUT_BYTES = b58d_pkg::OUT_BYTES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_empty,
	input  b58d_pkg::b58d_op_t pop_op,
	output logic               pop,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [7:0]         out_byte,
	output logic               decode_ok,
	output logic               last_byte
);

	localparam int NWORDS    = (OUT_BYTES + 3) / 4;
	localparam int REM_BYTES = OUT_BYTES % 4;
	localparam int W_IDX     = (NWORDS > 1) ? $clog2(NWORDS) : 1;
	localparam int BYTE_W    = (OUT_BYTES > 1) ? $clog2(OUT_BYTES) : 1;
	localparam logic [31:0] TOP_MASK =
		(REM_BYTES == 0) ? 32'h0 : (32'hffffffff << (8 * REM_BYTES));

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_MAC  = 2'd1;
	localparam logic [1:0] ST_EMIT = 2'd2;

	logic [1:0]        state_q;
	logic [31:0]       acc_q [NWORDS];
	logic              err_q;
	logic              end_q;
	logic [5:0]        carry_q;
	logic [W_IDX-1:0]  w_q;
	logic [BYTE_W-1:0] b_q;

	logic              out_valid_q;
	logic [7:0]        out_byte_q;
	logic              decode_ok_q;
	logic              last_byte_q;

	logic [W_IDX-1:0]  rd_idx;
	logic [31:0]       rd_word;
	logic [1:0]        lane;
	logic [37:0]       prod;
	logic              last_word;
	logic              slot_free;

	assign pop       = (state_q == ST_IDLE) && !q_empty;
	assign slot_free = !out_valid_q || out_ready;
	assign lane      = 2'(b_q);
	assign rd_idx    = (state_q == ST_EMIT) ? W_IDX'(b_q >> 2) : w_q;
	assign rd_word   = acc_q[rd_idx];
	assign prod      = 38'(rd_word) * 38'(b58d_pkg::RADIX) + 38'(carry_q);
	assign last_word = (w_q == W_IDX'(NWORDS - 1));

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign decode_ok = decode_ok_q;
	assign last_byte = last_byte_q;

	always_ff @(posedge clk) begin
		if (state_q == ST_EMIT && slot_free) begin
			out_byte_q  <= err_q ? 8'h00 : 8'(rd_word >> {lane, 3'b000});
			decode_ok_q <= !err_q;
			last_byte_q <= err_q || (b_q == '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			err_q       <= 1'b0;
			end_q       <= 1'b0;
			carry_q     <= '0;
			w_q         <= '0;
			b_q         <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < NWORDS; i++) begin
				acc_q[i] <= '0;
			end
		end else begin
			// while emitting, a taken transfer is replaced by the next byte below
			if (out_valid_q && out_ready && (state_q != ST_EMIT)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (pop) begin
						end_q <= pop_op.is_end;
						b_q   <= BYTE_W'(OUT_BYTES - 1);
						if (pop_op.is_char && !err_q && !pop_op.bad_char) begin
							carry_q <= pop_op.digit;
							w_q     <= '0;
							state_q <= ST_MAC;
						end else begin
							if (pop_op.is_char && pop_op.bad_char) begin
								err_q <= 1'b1;
							end
							state_q <= pop_op.is_end ? ST_EMIT : ST_IDLE;
						end
					end
				end
				ST_MAC: begin
					acc_q[w_q] <= prod[31:0];
					carry_q    <= prod[37:32];
					if (last_word) begin
						if (prod[37:32] != '0 || (prod[31:0] & TOP_MASK) != '0) begin
							err_q <= 1'b1;
						end
						state_q <= end_q ? ST_EMIT : ST_IDLE;
					end else begin
						w_q <= w_q + 1'b1;
					end
				end
				ST_EMIT: begin
					if (slot_free) begin
						out_valid_q <= 1'b1;
						if (err_q || b_q == '0) begin
							err_q   <= 1'b0;
							state_q <= ST_IDLE;
							for (int i = 0; i < NWORDS; i++) begin
								acc_q[i] <= '0;
							end
						end else begin
							b_q <= b_q - 1'b1;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

[tb/base58_decoder_unit_tb.sv]
module base58_decoder_unit_tb;

	localparam int OUT_BYTES = b58d_pkg::OUT_BYTES_DEF;
	localparam int NWORDS = (OUT_BYTES + 3) / 4;
	localparam int ACC_W = NWORDS * 32;
	// characters in digit order, first character in the top byte
	localparam logic [58*8-1:0] ALPHABET =
		"123456789ABCDEFGHJKLMNPQRSTUVWXYZabcdefghijkmnopqrstuvwxyz";
	localparam int RANDOM_ITEMS = 346;
	localparam int STALL_LIMIT = 3000;   // cycles with no transfer on either side
	localparam int HOLD_CYCLES = 400;    // one long receiver hold-off
	localparam int DRAIN_CYCLES = 40;

	// how a directed row gets its expected results
	typedef enum logic [1:0] {
		EXP_MODEL,   // from the predictor
		EXP_ZERO,    // all-zero bytes, decode ok
		EXP_ERROR    // single error transfer
	} check_kind_e;

	typedef struct packed {
		logic [7:0]  ch;
		logic        present;
		logic        eos;
		check_kind_e kind;
	} stim_row_t;

	typedef struct packed {
		logic [7:0] value;
		logic       ok;
		logic       last;
	} out_beat_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [7:0] text_char = 8'h00;
	logic       char_present = 1'b0;
	logic       end_of_string = 1'b0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [7:0] out_byte;
	logic       decode_ok;
	logic       last_byte;

	// predictor state
	logic [ACC_W-1:0] acc_value = '0;
	logic             acc_failed = 1'b0;

	out_beat_t   decoded_beats[$];   // results of the latest item from the predictor
	out_beat_t   pending_beats[$];   // results still owed by the block
	logic [7:0]  string_chars[$];    // text of the string being sent
	int          fail_count = 0;
	int          beats_seen = 0;
	int          items_sent = 0;
	bit          tx_burst = 1'b0;

	// directed part: field extremes, alphabet edges, bad characters, empty string
	localparam int DIRECTED_ROWS = 24;
	localparam stim_row_t DIRECTED[DIRECTED_ROWS] = '{
		'{8'h00, 1'b0, 1'b1, EXP_ZERO},    // empty string right after reset
		'{"1",   1'b1, 1'b1, EXP_ZERO},    // digit zero alone
		'{"z",   1'b1, 1'b1, EXP_MODEL},   // top digit
		'{8'h00, 1'b1, 1'b1, EXP_ERROR},   // nul is not in the alphabet
		'{8'hff, 1'b1, 1'b1, EXP_ERROR},   // top code
		'{8'haa, 1'b0, 1'b0, EXP_MODEL},   // neither char nor end: ignored
		'{"2",   1'b1, 1'b0, EXP_MODEL},
		'{"Z",   1'b1, 1'b0, EXP_MODEL},
		'{"a",   1'b1, 1'b0, EXP_MODEL},
		'{8'h55, 1'b0, 1'b1, EXP_MODEL},   // end on its own item
		'{"l",   1'b1, 1'b0, EXP_MODEL},   // lower-case l is missing from the alphabet
		'{"2",   1'b1, 1'b0, EXP_MODEL},   // skipped after the error
		'{"x",   1'b0, 1'b1, EXP_ERROR},
		'{"I",   1'b1, 1'b1, EXP_ERROR},
		'{"O",   1'b1, 1'b1, EXP_ERROR},
		'{"0",   1'b1, 1'b1, EXP_ERROR},
		'{"9",   1'b1, 1'b0, EXP_MODEL},   // edges of the alphabet ranges
		'{"A",   1'b1, 1'b0, EXP_MODEL},
		'{"H",   1'b1, 1'b0, EXP_MODEL},
		'{"J",   1'b1, 1'b0, EXP_MODEL},
		'{"k",   1'b1, 1'b0, EXP_MODEL},
		'{"m",   1'b1, 1'b1, EXP_MODEL},
		'{":",   1'b1, 1'b1, EXP_ERROR},   // just past '9'
		'{"{",   1'b1, 1'b1, EXP_ERROR}    // just past 'z'
	};

	base58_decoder_unit #(
		.OUT_BYTES(OUT_BYTES)
	) i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.text_char    (text_char),
		.char_present (char_present),
		.end_of_string(end_of_string),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.out_byte     (out_byte),
		.decode_ok    (decode_ok),
		.last_byte    (last_byte)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// position of a character in the alphabet, -1 when absent
	function automatic int digit_value(input logic [7:0] ch);
		for (int i = 0; i < 58; i++) begin
			if (ALPHABET[(57 - i) * 8 +: 8] == ch) begin
				return i;
			end
		end
		return -1;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) begin
			return 0;
		end else if (r < 85) begin
			return $urandom_range(1, 3);
		end else if (r < 97) begin
			return $urandom_range(4, 12);
		end
		return $urandom_range(20, 60);
	endfunction

	// advance the decode state by one item, results land in decoded_beats
	task automatic predict_decode(input logic [7:0] ch, input logic present,
		input logic eos);
		int                d;
		logic [ACC_W+5:0]  wide;
		out_beat_t         beat;
		decoded_beats.delete();
		if (present && !acc_failed) begin
			d = digit_value(ch);
			if (d < 0) begin
				acc_failed = 1'b1;
			end else begin
				wide = {6'b0, acc_value} * 58 + d;
				acc_value = wide[ACC_W-1:0];
				// carry out of the top word or any bit above the output width
				if ((wide >> (OUT_BYTES * 8)) != 0) begin
					acc_failed = 1'b1;
				end
			end
		end
		if (eos) begin
			if (acc_failed) begin
				beat = '{value: 8'h00, ok: 1'b0, last: 1'b1};
				decoded_beats.push_back(beat);
			end else begin
				for (int k = 0; k < OUT_BYTES; k++) begin
					beat.value = acc_value[(OUT_BYTES - 1 - k) * 8 +: 8];
					beat.ok = 1'b1;
					beat.last = (k == OUT_BYTES - 1);
					decoded_beats.push_back(beat);
				end
			end
			acc_value = '0;
			acc_failed = 1'b0;
		end
	endtask

	// offer one item after a random gap (none in burst mode) and wait for its transfer
	task automatic send_item(input logic [7:0] ch, input logic present, input logic eos,
		input check_kind_e kind);
		int        gap;
		out_beat_t beat;
		gap = tx_burst ? 0 : pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		text_char <= ch;
		char_present <= present;
		end_of_string <= eos;
		do begin
			@(posedge clk);
		end while (!in_ready);
		// transfer taken at this edge
		predict_decode(ch, present, eos);
		items_sent++;
		case (kind)
			EXP_ZERO: begin
				if (eos) begin
					for (int k = 0; k < OUT_BYTES; k++) begin
						beat = '{value: 8'h00, ok: 1'b1, last: (k == OUT_BYTES - 1)};
						pending_beats.push_back(beat);
					end
				end
			end
			EXP_ERROR: begin
				if (eos) begin
					beat = '{value: 8'h00, ok: 1'b0, last: 1'b1};
					pending_beats.push_back(beat);
				end
			end
			default: begin
				foreach (decoded_beats[i]) begin
					pending_beats.push_back(decoded_beats[i]);
				end
			end
		endcase
	endtask

	// send string_chars with scattered ignored items; the end rides on the
	// last character or comes as an item of its own
	task automatic send_string(input bit end_on_char);
		int n;
		n = string_chars.size();
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 9) == 0) begin
				send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0, EXP_MODEL);
			end
			send_item(string_chars[i], 1'b1, (end_on_char && i == n - 1), EXP_MODEL);
		end
		if (!end_on_char || n == 0) begin
			send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1, EXP_MODEL);
		end
	endtask

	// result side: random stalls, one long hold-off to back up the input
	initial begin
		int        stall;
		int        since_toggle;
		bit        rx_burst;
		bit        held;
		out_beat_t want;
		since_toggle = 0;
		rx_burst = 1'b0;
		held = 1'b0;
		do begin
			@(posedge clk);
		end while (!arst_n);
		forever begin
			if (!held && beats_seen >= 150) begin
				held = 1'b1;
				stall = HOLD_CYCLES;
			end else begin
				stall = rx_burst ? 0 : pick_gap();
			end
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			if (out_valid) begin
				beats_seen++;
				if (pending_beats.size() == 0) begin
					$error("result with nothing expected: out_byte %0h decode_ok %0b last_byte %0b",
						out_byte, decode_ok, last_byte);
					fail_count++;
				end else begin
					want = pending_beats.pop_front();
					if (out_byte !== want.value) begin
						$error("out_byte: expected %0h, got %0h", want.value, out_byte);
						fail_count++;
					end
					if (decode_ok !== want.ok) begin
						$error("decode_ok: expected %0b, got %0b", want.ok, decode_ok);
						fail_count++;
					end
					if (last_byte !== want.last) begin
						$error("last_byte: expected %0b, got %0b", want.last, last_byte);
						fail_count++;
					end
				end
			end
			// switch between stalling and streaming now and then
			since_toggle++;
			if (since_toggle >= 64) begin
				since_toggle = 0;
				if ($urandom_range(0, 3) == 0) begin
					rx_burst = ~rx_burst;
				end
			end
		end
	end

	// watchdog: ends the run after too long without any transfer
	initial begin
		int idle;
		idle = 0;
		forever begin
			@(posedge clk);
			if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
				idle = 0;
			end else begin
				idle++;
				if (idle >= STALL_LIMIT) begin
					$display("base58_decoder_unit test failed");
					$finish;
				end
			end
		end
	end

	initial begin
		int r;
		int len;
		int long_strings;
		logic [7:0] ch;
		long_strings = 0;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < DIRECTED_ROWS; i++) begin
			send_item(DIRECTED[i].ch, DIRECTED[i].present, DIRECTED[i].eos, DIRECTED[i].kind);
		end

		items_sent = 0;
		while (items_sent < RANDOM_ITEMS) begin
			if ($urandom_range(0, 9) == 0) begin
				tx_burst = ~tx_burst;
			end
			string_chars.delete();
			r = $urandom_range(0, 99);
			if (r < 6 && long_strings < 4) begin
				// long strings around the overflow edge, 34 of 'z' still fits
				long_strings++;
				len = $urandom_range(33, 36);
				for (int i = 0; i < len; i++) begin
					string_chars.push_back(r < 3 ? 8'("z")
						: ALPHABET[$urandom_range(0, 57) * 8 +: 8]);
				end
			end else if (r < 70) begin
				// well-formed string with random content
				len = $urandom_range(0, 8);
				for (int i = 0; i < len; i++) begin
					string_chars.push_back(ALPHABET[$urandom_range(0, 57) * 8 +: 8]);
				end
			end else if (r < 85) begin
				// well-formed string broken by one bad character
				len = $urandom_range(1, 6);
				for (int i = 0; i < len; i++) begin
					string_chars.push_back(ALPHABET[$urandom_range(0, 57) * 8 +: 8]);
				end
				do begin
					ch = 8'($urandom_range(0, 255));
				end while (digit_value(ch) >= 0);
				string_chars.insert($urandom_range(0, len), ch);
			end else if (r < 95) begin
				// raw bytes, mostly outside the alphabet
				len = $urandom_range(1, 4);
				for (int i = 0; i < len; i++) begin
					string_chars.push_back(8'($urandom_range(0, 255)));
				end
			end
			// anything else stays empty: end mark alone
			send_string($urandom_range(0, 1));
		end
		in_valid <= 1'b0;

		while (pending_beats.size() != 0) begin
			@(posedge clk);
		end
		// give a stray transfer time to show up
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0) begin
			$display("base58_decoder_unit test passed");
		end else begin
			$display("base58_decoder_unit test failed");
		end
		$finish;
	end

endmodule
